// File: sv/tii_pkg.sv
`default_nettype none
package tii_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] OC_EXACT    = 3'd0;
    localparam logic [2:0] OC_INTERP   = 3'd1;
    localparam logic [2:0] OC_NEAREST  = 3'd2;
    localparam logic [2:0] OC_NOTFOUND = 3'd3;
    localparam logic [2:0] OC_DROPPED  = 3'd4;

    localparam logic [1:0] RSEL_ZERO   = 2'd0;
    localparam logic [1:0] RSEL_RDX    = 2'd1;
    localparam logic [1:0] RSEL_INTERP = 2'd2;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       query_init;
        logic       set_mid;
        logic       rd_next;
        logic       latch_m;
        logic       narrow;
        logic       latch_interp;
        logic       mul;
        logic       div_start;
        logic       fin_load;
        logic [1:0] fin_sel;
        logic [2:0] fin_code;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic lr_ok;
        logic eq;
        logic near;
        logic brk;
        logic div_done;
    } t_dp_sts;
endpackage
`default_nettype wire

// File: sv/tii_ram.sv
`default_nettype none
module tii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/tii_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle. Needs dividend[63:32] < divisor.
module tii_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_sh;
    logic        r_done;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_sh[31]};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_sh  <= i_dividend[31:0];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, i_divisor}) : trial[31:0];
            r_sh  <= {r_sh[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;
endmodule
`default_nettype wire

// File: sv/tii_dp.sv
`default_nettype none
module tii_dp #(
    parameter int DEPTH = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tii_pkg::t_dp_cmd i_cmd,
    output tii_pkg::t_dp_sts     o_sts,
    input  wire logic [31:0]     i_point_x,
    input  wire logic [31:0]     i_point_y,
    input  wire logic [31:0]     i_query_y,
    output logic [31:0]          o_result_x,
    output logic [2:0]           o_outcome
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = CW + 1;

    logic [CW-1:0]        r_count;
    logic signed [LW-1:0] r_l, r_r;
    logic [AW-1:0]        r_mid;
    logic [31:0]          r_q, r_ym, r_xm, r_num, r_den, r_mag;
    logic                 r_neg;
    logic [63:0]          r_prod;
    logic [31:0]          r_fin_x, r_out_x;
    logic [2:0]           r_fin_code, r_out_code;

    logic [LW:0]          lr_sum;
    logic [AW-1:0]        mid_c, raddr;
    logic signed [LW-1:0] mid_ext;
    logic [31:0]          rd_x, rd_y, quo, interp_x;
    logic signed [32:0]   dx;
    logic                 div_done;

    assign lr_sum  = (LW+1)'(r_l) + (LW+1)'(r_r);
    assign mid_c   = lr_sum[AW:1];
    assign mid_ext = $signed({{(LW-AW){1'b0}}, r_mid});
    assign raddr   = i_cmd.rd_next ? AW'(r_mid + 1'b1) : mid_c;
    assign dx      = $signed({rd_x[31], rd_x}) - $signed({r_xm[31], r_xm});
    assign interp_x = r_neg ? r_xm - quo : r_xm + quo;

    tii_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_xram (
        .i_clk(i_clk), .i_we(i_cmd.append), .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_point_x), .i_raddr(raddr), .o_rdata(rd_x)
    );
    tii_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_yram (
        .i_clk(i_clk), .i_we(i_cmd.append), .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_point_y), .i_raddr(raddr), .o_rdata(rd_y)
    );
    tii_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(r_prod), .i_divisor(r_den), .o_done(div_done), .o_quotient(quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_init) begin
            r_q <= i_query_y;
            r_l <= '0;
            r_r <= $signed(LW'(r_count));
        end
        if (i_cmd.set_mid) begin
            r_mid <= mid_c;
        end
        if (i_cmd.latch_m) begin
            r_ym <= rd_y;
            r_xm <= rd_x;
        end
        if (i_cmd.narrow) begin
            if ($signed(r_ym) > $signed(r_q)) begin
                r_r <= mid_ext - LW'(1);
            end else begin
                r_l <= mid_ext + LW'(1);
            end
        end
        if (i_cmd.latch_interp) begin
            r_num <= r_q - r_ym;
            r_den <= rd_y - r_ym;
            r_neg <= dx[32];
            r_mag <= dx[32] ? 32'(-dx) : dx[31:0];
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_num) * 64'(r_mag);
        end
        if (i_cmd.fin_load) begin
            r_fin_code <= i_cmd.fin_code;
            case (i_cmd.fin_sel)
                tii_pkg::RSEL_RDX:    r_fin_x <= rd_x;
                tii_pkg::RSEL_INTERP: r_fin_x <= interp_x;
                default:              r_fin_x <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_x    <= r_fin_x;
            r_out_code <= r_fin_code;
        end
    end

    assign o_sts.empty    = r_count == '0;
    assign o_sts.full     = r_count == CW'(DEPTH);
    assign o_sts.lr_ok    = r_l <= r_r;
    assign o_sts.eq       = rd_y == r_q;
    assign o_sts.near     = (mid_ext + LW'(1)) >= r_r;
    assign o_sts.brk      = ($signed(r_ym) < $signed(r_q)) && ($signed(rd_y) > $signed(r_q));
    assign o_sts.div_done = div_done;

    assign o_result_x = r_out_x;
    assign o_outcome  = r_out_code;
endmodule
`default_nettype wire

// File: sv/tii_ctrl.sv
`default_nettype none
module tii_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_command,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tii_pkg::t_dp_cmd      o_cmd,
    input  wire tii_pkg::t_dp_sts i_sts
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CHK0 = 4'd2;
    localparam logic [3:0] S_CHK1 = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DST  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]       r_state, n_state;
    logic             r_out_valid, n_out_valid;
    tii_pkg::t_dp_cmd c;

    always_comb begin
        c        = '0;
        n_state  = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        tii_pkg::CMD_CLEAR: c.clear = 1'b1;
                        tii_pkg::CMD_APPEND: begin
                            if (i_sts.full) begin
                                c.fin_load = 1'b1;
                                c.fin_sel  = tii_pkg::RSEL_ZERO;
                                c.fin_code = tii_pkg::OC_DROPPED;
                                n_state    = S_OUT;
                            end else begin
                                c.append = 1'b1;
                            end
                        end
                        tii_pkg::CMD_QUERY: begin
                            c.query_init = 1'b1;
                            if (i_sts.empty) begin
                                c.fin_load = 1'b1;
                                c.fin_sel  = tii_pkg::RSEL_ZERO;
                                c.fin_code = tii_pkg::OC_NOTFOUND;
                                n_state    = S_OUT;
                            end else begin
                                n_state = S_RD0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD0: begin
                if (i_sts.lr_ok) begin
                    c.set_mid = 1'b1;
                    n_state   = S_CHK0;
                end else begin
                    c.fin_load = 1'b1;
                    c.fin_sel  = tii_pkg::RSEL_ZERO;
                    c.fin_code = tii_pkg::OC_NOTFOUND;
                    n_state    = S_OUT;
                end
            end
            S_CHK0: begin
                c.latch_m = 1'b1;
                c.rd_next = 1'b1;
                if (i_sts.eq || i_sts.near) begin
                    c.fin_load = 1'b1;
                    c.fin_sel  = tii_pkg::RSEL_RDX;
                    c.fin_code = i_sts.eq ? tii_pkg::OC_EXACT : tii_pkg::OC_NEAREST;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_CHK1;
                end
            end
            S_CHK1: begin
                if (i_sts.brk) begin
                    c.latch_interp = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    c.narrow = 1'b1;
                    n_state  = S_RD0;
                end
            end
            S_MUL: begin
                c.mul   = 1'b1;
                n_state = S_DST;
            end
            S_DST: begin
                c.div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    c.fin_load = 1'b1;
                    c.fin_sel  = tii_pkg::RSEL_INTERP;
                    c.fin_code = tii_pkg::OC_INTERP;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    c.out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = c;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// File: sv/table_inverse_interpolation.sv
`default_nettype none
// Channel   | Direction | Payload
// s_axis    | in        | tdata: command[1:0] point_x[33:2] point_y[65:34] query_y[97:66]
// m_axis    | out       | tdata: result_x[31:0] outcome[34:32]
//
// Clear and append are done in the idle state; an append into a full
// table and an empty query finish through the output state. A query spends
// states RD0, CHK0 and CHK1 on each probe of the block RAMs (at most about
// log2(TABLE_DEPTH)+2 probes): a hit ends in CHK0, a failed search in RD0,
// and an interpolation goes on through the multiply and the bit-serial divider.
// Synchronous active-low reset empties the table; RAM contents are kept.
// A stalled result sits in the output register; the next request is taken
// meanwhile and its result waits until that register is free.
module table_inverse_interpolation #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [103:0] i_s_axis_tdata,  // command, point_x, point_y, query_y
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [39:0]       o_m_axis_tdata   // result_x, outcome
);
    tii_pkg::t_dp_cmd cmd;
    tii_pkg::t_dp_sts sts;
    logic [31:0]      result_x;
    logic [2:0]       outcome;

    tii_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_s_axis_tvalid), .i_command(i_s_axis_tdata[1:0]),
        .o_in_ready(o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid), .i_out_ready(i_m_axis_tready),
        .o_cmd(cmd), .i_sts(sts)
    );

    tii_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_point_x(i_s_axis_tdata[33:2]), .i_point_y(i_s_axis_tdata[65:34]),
        .i_query_y(i_s_axis_tdata[97:66]),
        .o_result_x(result_x), .o_outcome(outcome)
    );

    assign o_m_axis_tdata = {5'd0, outcome, result_x};
endmodule
`default_nettype wire
